// ----- sv/obb_pkg.sv -----
// Shared constants, types and field helpers for the oriented-box overlap test.
package obb_pkg;

  localparam int COORD_BITS     = 16;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_BITS      = AXIS_FRAC_BITS + 2;
  localparam int FIELD_W        = 48;
  localparam int FLAGS_W        = 2;
  localparam int EPS_W          = 8;
  localparam logic [EPS_W-1:0] EPS_RESET = 8'd2;

  localparam int D_W     = COORD_BITS + 1;
  localparam int DOT_W   = 2 * AXIS_BITS + 2;
  localparam int R_W     = DOT_W - AXIS_FRAC_BITS;
  localparam int AR_W    = R_W + 2;
  localparam int DA_W    = D_W + AXIS_BITS + 2;
  localparam int OV_W    = COORD_BITS + AR_W + 4;
  localparam int LO_W    = DA_W / 2;
  localparam int HI_W    = DA_W - LO_W;
  localparam int PLO_W   = LO_W + 1 + R_W;
  localparam int PHI_W   = HI_W + R_W;
  localparam int X_W     = DA_W + R_W + 3;
  localparam int RR_W    = COORD_BITS + AR_W + 2;
  localparam int NRM_W   = AXIS_BITS + 1;
  localparam int DEPTH_W = 16;
  localparam int KIND_W  = 2;
  localparam int FACES   = 6;
  localparam int IDX_W   = 3;

  localparam int FLAG_TRIGGER = 0;
  localparam int FLAG_LOCKED  = 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic signed [NRM_W-1:0] NRM_LIM = NRM_W'((1 << (AXIS_BITS - 1)) - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_DEFAULT = 2'd1,
    KIND_LOCKED  = 2'd2
  } kind_e;

  function automatic logic signed [COORD_BITS-1:0] coord_slot(
      input logic [FIELD_W-1:0] w, input int k);
    return w[k*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] axis_slot(
      input logic [FIELD_W-1:0] w, input int k);
    return w[k*AXIS_BITS +: AXIS_BITS];
  endfunction

endpackage

// ----- sv/obb_in_if.sv -----
// Input channel: one box pair per beat.
interface obb_in_if;
  logic                        valid;
  logic                        ready;
  logic [obb_pkg::FIELD_W-1:0] a_center;
  logic [obb_pkg::FIELD_W-1:0] a_axis_0;
  logic [obb_pkg::FIELD_W-1:0] a_axis_1;
  logic [obb_pkg::FIELD_W-1:0] a_axis_2;
  logic [obb_pkg::FIELD_W-1:0] a_half;
  logic [obb_pkg::FLAGS_W-1:0] a_flags;
  logic [obb_pkg::FIELD_W-1:0] b_center;
  logic [obb_pkg::FIELD_W-1:0] b_axis_0;
  logic [obb_pkg::FIELD_W-1:0] b_axis_1;
  logic [obb_pkg::FIELD_W-1:0] b_axis_2;
  logic [obb_pkg::FIELD_W-1:0] b_half;
  logic [obb_pkg::FLAGS_W-1:0] b_flags;

  modport source(output valid, a_center, a_axis_0, a_axis_1, a_axis_2, a_half, a_flags,
                 b_center, b_axis_0, b_axis_1, b_axis_2, b_half, b_flags, input ready);
  modport sink(input valid, a_center, a_axis_0, a_axis_1, a_axis_2, a_half, a_flags,
               b_center, b_axis_0, b_axis_1, b_axis_2, b_half, b_flags, output ready);
endinterface

// ----- sv/obb_out_if.sv -----
// Output channel: one contact result per beat.
interface obb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        overlapping;
  logic                        solid_hit;
  logic                        trigger_hit;
  logic [obb_pkg::FIELD_W-1:0] normal_for_a;
  logic [obb_pkg::FIELD_W-1:0] normal_for_b;
  logic [obb_pkg::DEPTH_W-1:0] depth;
  logic [obb_pkg::KIND_W-1:0]  kind_seen_by_a;
  logic [obb_pkg::KIND_W-1:0]  kind_seen_by_b;

  modport source(output valid, overlapping, solid_hit, trigger_hit, normal_for_a,
                 normal_for_b, depth, kind_seen_by_a, kind_seen_by_b, input ready);
  modport sink(input valid, overlapping, solid_hit, trigger_hit, normal_for_a,
               normal_for_b, depth, kind_seen_by_a, kind_seen_by_b, output ready);
endinterface

// ----- sv/obb_pair_overlap_test.sv -----
// Five-stage pipelined separating axis test for a pair of oriented boxes.
//
//  channel   dir   handshake      beat
//  in_i      in    valid/ready    two boxes: centers, axes, half sizes, flags
//  out_o     out   valid/ready    overlap, hit kind, normals, depth, kinds
//  cfg       in    cfg_we_i       axis_epsilon, 8 bits
//
// One pair per cycle sustained while out_o is ready. Stage 5 is the output register.
// Stages: rotation/projection dots, abs terms, face overlaps and split cross
// products, pairwise min and cross differences, final compare and result build.
// Back-pressure stalls all stages together; nothing is dropped or replayed.
// Reset clears the stage valids and sets axis_epsilon to 2.
module obb_pair_overlap_test (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [obb_pkg::EPS_W-1:0]   cfg_wdata_i,
  obb_in_if.sink                      in_i,
  obb_out_if.source                   out_o
);

  localparam int F = obb_pkg::AXIS_FRAC_BITS;
  localparam int C = obb_pkg::COORD_BITS;
  localparam int A = obb_pkg::AXIS_BITS;

  logic [obb_pkg::EPS_W-1:0] eps_q;
  logic [4:0]                v_q;
  logic                      en;

  assign en         = !v_q[4] || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= obb_pkg::EPS_RESET;
      v_q   <= '0;
    end else begin
      if (cfg_we_i) eps_q <= cfg_wdata_i;
      if (en) v_q <= {v_q[3:0], in_i.valid};
    end
  end

  // ---------------- stage 1 ----------------
  logic signed [C-1:0] ac[3], bc[3], ah_d[3], bh_d[3];
  logic signed [A-1:0] aa_d[3][3], ba_d[3][3];
  logic signed [obb_pkg::D_W-1:0] dv[3];
  logic signed [obb_pkg::R_W-1:0] r1_d[3][3];
  logic signed [obb_pkg::DA_W-1:0] da1_d[3], db1_d[3];

  always_comb begin
    logic signed [obb_pkg::DOT_W-1:0] dot;
    logic signed [obb_pkg::DA_W-1:0] sa, sb;
    for (int k = 0; k < 3; k++) begin
      ac[k]   = obb_pkg::coord_slot(in_i.a_center, k);
      bc[k]   = obb_pkg::coord_slot(in_i.b_center, k);
      ah_d[k] = obb_pkg::coord_slot(in_i.a_half, k);
      bh_d[k] = obb_pkg::coord_slot(in_i.b_half, k);
      aa_d[0][k] = obb_pkg::axis_slot(in_i.a_axis_0, k);
      aa_d[1][k] = obb_pkg::axis_slot(in_i.a_axis_1, k);
      aa_d[2][k] = obb_pkg::axis_slot(in_i.a_axis_2, k);
      ba_d[0][k] = obb_pkg::axis_slot(in_i.b_axis_0, k);
      ba_d[1][k] = obb_pkg::axis_slot(in_i.b_axis_1, k);
      ba_d[2][k] = obb_pkg::axis_slot(in_i.b_axis_2, k);
      dv[k] = obb_pkg::D_W'(bc[k]) - obb_pkg::D_W'(ac[k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dot = '0;
        for (int k = 0; k < 3; k++)
          dot = dot + obb_pkg::DOT_W'(aa_d[i][k]) * obb_pkg::DOT_W'(ba_d[j][k]);
        r1_d[i][j] = obb_pkg::R_W'(dot >>> F);
      end
      sa = '0;
      sb = '0;
      for (int k = 0; k < 3; k++) begin
        sa = sa + obb_pkg::DA_W'(dv[k]) * obb_pkg::DA_W'(aa_d[i][k]);
        sb = sb + obb_pkg::DA_W'(dv[k]) * obb_pkg::DA_W'(ba_d[i][k]);
      end
      da1_d[i] = sa;
      db1_d[i] = sb;
    end
  end

  logic signed [obb_pkg::R_W-1:0]  r1_q[3][3];
  logic signed [obb_pkg::DA_W-1:0] da1_q[3], db1_q[3];
  logic signed [C-1:0]             ah1_q[3], bh1_q[3];
  logic signed [A-1:0]             aa1_q[3][3], ba1_q[3][3];
  logic [obb_pkg::FLAGS_W-1:0]     af1_q, bf1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= r1_d;
      da1_q <= da1_d;
      db1_q <= db1_d;
      ah1_q <= ah_d;
      bh1_q <= bh_d;
      aa1_q <= aa_d;
      ba1_q <= ba_d;
      af1_q <= in_i.a_flags;
      bf1_q <= in_i.b_flags;
    end
  end

  // ---------------- stage 2 ----------------
  logic signed [obb_pkg::AR_W-1:0] ar2_d[3][3];
  logic signed [obb_pkg::DA_W:0]   ada2_d[3], adb2_d[3];

  always_comb begin
    logic signed [obb_pkg::AR_W-1:0] rv;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rv = obb_pkg::AR_W'(r1_q[i][j]);
        ar2_d[i][j] = (rv < 0 ? -rv : rv) + obb_pkg::AR_W'({1'b0, eps_q});
      end
      ada2_d[i] = da1_q[i] < 0 ? -(obb_pkg::DA_W+1)'(da1_q[i]) : (obb_pkg::DA_W+1)'(da1_q[i]);
      adb2_d[i] = db1_q[i] < 0 ? -(obb_pkg::DA_W+1)'(db1_q[i]) : (obb_pkg::DA_W+1)'(db1_q[i]);
    end
  end

  logic signed [obb_pkg::AR_W-1:0] ar2_q[3][3];
  logic signed [obb_pkg::DA_W:0]   ada2_q[3], adb2_q[3];
  logic signed [obb_pkg::R_W-1:0]  r2_q[3][3];
  logic signed [obb_pkg::DA_W-1:0] da2_q[3];
  logic [2:0]                      fa2_q, fb2_q;
  logic signed [C-1:0]             ah2_q[3], bh2_q[3];
  logic signed [A-1:0]             aa2_q[3][3], ba2_q[3][3];
  logic [obb_pkg::FLAGS_W-1:0]     af2_q, bf2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ar2_q  <= ar2_d;
      ada2_q <= ada2_d;
      adb2_q <= adb2_d;
      r2_q   <= r1_q;
      da2_q  <= da1_q;
      for (int i = 0; i < 3; i++) begin
        fa2_q[i] <= da1_q[i] > 0;
        fb2_q[i] <= db1_q[i] > 0;
      end
      ah2_q <= ah1_q;
      bh2_q <= bh1_q;
      aa2_q <= aa1_q;
      ba2_q <= ba1_q;
      af2_q <= af1_q;
      bf2_q <= bf1_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic signed [obb_pkg::OV_W-1:0]  ov3_d[obb_pkg::FACES];
  logic signed [obb_pkg::PLO_W-1:0] plo3_d[9][2];
  logic signed [obb_pkg::PHI_W-1:0] phi3_d[9][2];
  logic signed [obb_pkg::RR_W-1:0]  rr3_d[9];

  always_comb begin
    logic signed [obb_pkg::OV_W-1:0] sa, sb;
    logic signed [obb_pkg::RR_W-1:0] rt, ro;
    logic signed [obb_pkg::DA_W-1:0] dx[2];
    logic signed [obb_pkg::R_W-1:0]  rx[2];
    int i1, i2, j1, j2, n;
    for (int i = 0; i < 3; i++) begin
      sa = obb_pkg::OV_W'(ah2_q[i]) <<< F;
      sb = obb_pkg::OV_W'(bh2_q[i]) <<< F;
      for (int k = 0; k < 3; k++) begin
        sa = sa + obb_pkg::OV_W'(bh2_q[k]) * obb_pkg::OV_W'(ar2_q[i][k]);
        sb = sb + obb_pkg::OV_W'(ah2_q[k]) * obb_pkg::OV_W'(ar2_q[k][i]);
      end
      ov3_d[i]     = sa - obb_pkg::OV_W'(ada2_q[i]);
      ov3_d[i + 3] = sb - obb_pkg::OV_W'(adb2_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        n  = i * 3 + j;
        dx[0] = da2_q[i2];
        rx[0] = r2_q[i1][j];
        dx[1] = da2_q[i1];
        rx[1] = r2_q[i2][j];
        for (int p = 0; p < 2; p++) begin
          plo3_d[n][p] = obb_pkg::PLO_W'($signed({1'b0, dx[p][obb_pkg::LO_W-1:0]}))
                         * obb_pkg::PLO_W'(rx[p]);
          phi3_d[n][p] = obb_pkg::PHI_W'($signed(dx[p][obb_pkg::DA_W-1:obb_pkg::LO_W]))
                         * obb_pkg::PHI_W'(rx[p]);
        end
        rt = obb_pkg::RR_W'(ah2_q[i1]) * obb_pkg::RR_W'(ar2_q[i2][j])
           + obb_pkg::RR_W'(ah2_q[i2]) * obb_pkg::RR_W'(ar2_q[i1][j]);
        ro = obb_pkg::RR_W'(bh2_q[j1]) * obb_pkg::RR_W'(ar2_q[i][j2])
           + obb_pkg::RR_W'(bh2_q[j2]) * obb_pkg::RR_W'(ar2_q[i][j1]);
        rr3_d[n] = rt + ro;
      end
    end
  end

  logic signed [obb_pkg::OV_W-1:0]  ov3_q[obb_pkg::FACES];
  logic signed [obb_pkg::PLO_W-1:0] plo3_q[9][2];
  logic signed [obb_pkg::PHI_W-1:0] phi3_q[9][2];
  logic signed [obb_pkg::RR_W-1:0]  rr3_q[9];
  logic [2:0]                       fa3_q, fb3_q;
  logic signed [A-1:0]              aa3_q[3][3], ba3_q[3][3];
  logic [obb_pkg::FLAGS_W-1:0]      af3_q, bf3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ov3_q  <= ov3_d;
      plo3_q <= plo3_d;
      phi3_q <= phi3_d;
      rr3_q  <= rr3_d;
      fa3_q  <= fa2_q;
      fb3_q  <= fb2_q;
      aa3_q  <= aa2_q;
      ba3_q  <= ba2_q;
      af3_q  <= af2_q;
      bf3_q  <= bf2_q;
    end
  end

  // ---------------- stage 4 ----------------
  logic signed [obb_pkg::X_W-1:0]  t4_d[9];
  logic signed [obb_pkg::OV_W-1:0] m4_d[3];
  logic [obb_pkg::IDX_W-1:0]       mi4_d[3];
  logic                            sepf4_d;

  always_comb begin
    logic signed [obb_pkg::X_W-1:0] pp[2];
    sepf4_d = 1'b0;
    for (int f = 0; f < obb_pkg::FACES; f++)
      if (ov3_q[f] < 0) sepf4_d = 1'b1;
    for (int n = 0; n < 9; n++) begin
      for (int p = 0; p < 2; p++)
        pp[p] = (obb_pkg::X_W'(phi3_q[n][p]) <<< obb_pkg::LO_W) + obb_pkg::X_W'(plo3_q[n][p]);
      t4_d[n] = pp[0] - pp[1];
    end
    for (int g = 0; g < 3; g++) begin
      if (ov3_q[2*g+1] < ov3_q[2*g]) begin
        m4_d[g]  = ov3_q[2*g+1];
        mi4_d[g] = obb_pkg::IDX_W'(2*g+1);
      end else begin
        m4_d[g]  = ov3_q[2*g];
        mi4_d[g] = obb_pkg::IDX_W'(2*g);
      end
    end
  end

  logic signed [obb_pkg::X_W-1:0]  t4_q[9];
  logic signed [obb_pkg::RR_W-1:0] rr4_q[9];
  logic signed [obb_pkg::OV_W-1:0] m4_q[3];
  logic [obb_pkg::IDX_W-1:0]       mi4_q[3];
  logic                            sepf4_q;
  logic [2:0]                      fa4_q, fb4_q;
  logic signed [A-1:0]             aa4_q[3][3], ba4_q[3][3];
  logic [obb_pkg::FLAGS_W-1:0]     af4_q, bf4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q    <= t4_d;
      rr4_q   <= rr3_q;
      m4_q    <= m4_d;
      mi4_q   <= mi4_d;
      sepf4_q <= sepf4_d;
      fa4_q   <= fa3_q;
      fb4_q   <= fb3_q;
      aa4_q   <= aa3_q;
      ba4_q   <= ba3_q;
      af4_q   <= af3_q;
      bf4_q   <= bf3_q;
    end
  end

  // ---------------- stage 5: result ----------------
  logic                            sep5;
  logic signed [obb_pkg::OV_W-1:0] best5;
  logic [obb_pkg::IDX_W-1:0]       bi5;
  logic signed [A-1:0]             ax5[3];
  logic                            flip5;
  logic signed [obb_pkg::NRM_W-1:0] n5[3], nn5[3];
  logic signed [obb_pkg::OV_W-1:0] dep5;
  logic                            trig5, solid5;
  logic [obb_pkg::FIELD_W-1:0]     na_d, nb_d;
  logic [obb_pkg::DEPTH_W-1:0]     depth_d;
  logic [obb_pkg::KIND_W-1:0]      ka_d, kb_d;

  always_comb begin
    logic signed [obb_pkg::X_W-1:0] at;
    sep5 = sepf4_q;
    for (int n = 0; n < 9; n++) begin
      at = t4_q[n] < 0 ? -t4_q[n] : t4_q[n];
      if ((obb_pkg::X_W'(rr4_q[n]) <<< F) < at) sep5 = 1'b1;
    end
    best5 = m4_q[0];
    bi5   = mi4_q[0];
    for (int g = 1; g < 3; g++) begin
      if (m4_q[g] < best5) begin
        best5 = m4_q[g];
        bi5   = mi4_q[g];
      end
    end
    for (int k = 0; k < 3; k++) ax5[k] = '0;
    flip5 = 1'b0;
    for (int f = 0; f < obb_pkg::FACES; f++) begin
      if (bi5 == obb_pkg::IDX_W'(f)) begin
        for (int k = 0; k < 3; k++)
          ax5[k] = (f < 3) ? aa4_q[f % 3][k] : ba4_q[f % 3][k];
        flip5 = (f < 3) ? fa4_q[f % 3] : fb4_q[f % 3];
      end
    end
    trig5  = af4_q[obb_pkg::FLAG_TRIGGER] || bf4_q[obb_pkg::FLAG_TRIGGER];
    solid5 = !sep5 && !trig5;
    na_d = '0;
    nb_d = '0;
    for (int k = 0; k < 3; k++) begin
      n5[k]  = flip5 ? -obb_pkg::NRM_W'(ax5[k]) : obb_pkg::NRM_W'(ax5[k]);
      nn5[k] = -n5[k];
      if (n5[k] > obb_pkg::NRM_LIM) n5[k] = obb_pkg::NRM_LIM;
      if (nn5[k] > obb_pkg::NRM_LIM) nn5[k] = obb_pkg::NRM_LIM;
      na_d[k*A +: A] = n5[k][A-1:0];
      nb_d[k*A +: A] = nn5[k][A-1:0];
    end
    dep5 = best5 >>> F;
    depth_d = (dep5 > obb_pkg::OV_W'(obb_pkg::DEPTH_MAX)) ? obb_pkg::DEPTH_MAX
                                                          : dep5[obb_pkg::DEPTH_W-1:0];
    ka_d = bf4_q[obb_pkg::FLAG_LOCKED] ? obb_pkg::KIND_LOCKED : obb_pkg::KIND_DEFAULT;
    kb_d = af4_q[obb_pkg::FLAG_LOCKED] ? obb_pkg::KIND_LOCKED : obb_pkg::KIND_DEFAULT;
    if (!solid5) begin
      na_d    = '0;
      nb_d    = '0;
      depth_d = '0;
      ka_d    = obb_pkg::KIND_NONE;
      kb_d    = obb_pkg::KIND_NONE;
    end
  end

  logic                        ovl_q, solid_q, trig_q;
  logic [obb_pkg::FIELD_W-1:0] na_q, nb_q;
  logic [obb_pkg::DEPTH_W-1:0] depth_q;
  logic [obb_pkg::KIND_W-1:0]  ka_q, kb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ovl_q   <= !sep5;
      solid_q <= solid5;
      trig_q  <= !sep5 && trig5;
      na_q    <= na_d;
      nb_q    <= nb_d;
      depth_q <= depth_d;
      ka_q    <= ka_d;
      kb_q    <= kb_d;
    end
  end

  assign out_o.overlapping    = ovl_q;
  assign out_o.solid_hit      = solid_q;
  assign out_o.trigger_hit    = trig_q;
  assign out_o.normal_for_a   = na_q;
  assign out_o.normal_for_b   = nb_q;
  assign out_o.depth          = depth_q;
  assign out_o.kind_seen_by_a = ka_q;
  assign out_o.kind_seen_by_b = kb_q;

endmodule
